FILE: rtl/fgp_pkg.sv
package fgp_pkg;

    // Request commands.
    localparam logic [1:0] CMD_MAP   = 2'd0;
    localparam logic [1:0] CMD_EVICT = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Response status codes.
    localparam logic [2:0] ST_PLACED  = 3'd0;
    localparam logic [2:0] ST_PRESENT = 3'd1;
    localparam logic [2:0] ST_LIMIT   = 3'd2;
    localparam logic [2:0] ST_NOCELL  = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    // Configuration register indexes.
    localparam logic REG_FOLD_EN = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    localparam int CNT_W   = 5;
    localparam int CNT_MAX = 31;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  virt_row;
        logic [11:0] virt_col;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  phys_row;
        logic [3:0]  phys_col;
        logic        row_folded;
        logic [31:0] fold_total;
    } t_rsp;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/fgp_ram.sv
module fgp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fgp_ctrl.sv
module fgp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_in_cmd,
    input  fgp_pkg::t_sts i_sts,
    output fgp_pkg::t_cmd o_cmd,
    output logic          o_idle
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state, n_state;
    fgp_pkg::t_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    if (i_in_cmd inside {fgp_pkg::CMD_MAP, fgp_pkg::CMD_EVICT}) begin
                        w_cmd.scan = 1'b1;
                        n_state    = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    w_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_idle = (r_state == S_IDLE);

`ifndef NO_ASSERTIONS
    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> i_sts.out_free)
        else $error("execute step issued while the response register is busy");
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.scan_done) |=> (r_state == S_EXEC))
        else $error("scan completion did not lead to the execute step");
`endif

endmodule

FILE: rtl/fgp_datapath.sv
module fgp_datapath #(
    parameter int PHYS_ROWS  = 16,
    parameter int PHYS_COLS  = 16,
    parameter int VCOL_WIDTH = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fgp_pkg::t_cmd i_cmd,
    output fgp_pkg::t_sts o_sts,
    input  fgp_pkg::t_req i_req,
    input  logic          i_fold_en,
    input  logic [3:0]    i_limit,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output fgp_pkg::t_rsp o_rsp
);

    localparam int RW = $clog2(PHYS_ROWS);
    localparam int CW = $clog2(PHYS_COLS);
    localparam int EW = 4 + VCOL_WIDTH;

    // Latched request.
    logic [1:0]            r_cmd;
    logic [3:0]            r_vr;
    logic [VCOL_WIDTH-1:0] r_vc;

    // Cell occupancy and per-row state.
    logic [PHYS_COLS-1:0]     r_valid [PHYS_ROWS];
    logic [fgp_pkg::CNT_W-1:0] r_cnt  [16];
    logic [15:0]              r_mark;
    logic [31:0]              r_fold_cnt;

    // Scan pipeline: read issue, then compare in the following cycle.
    logic          r_rd_act, r_cmp_act;
    logic [RW-1:0] r_rd_row, r_cmp_row;

    // Scan results.
    logic          r_hit, r_lfound;
    logic [RW-1:0] r_hr, r_lr;
    logic [CW-1:0] r_hc, r_lc;

    logic          r_out_valid;
    fgp_pkg::t_rsp r_rsp;

    // Column memories, one entry per physical row.
    logic [EW-1:0]    w_rdata [PHYS_COLS];
    logic [PHYS_COLS-1:0] w_we;
    logic [RW-1:0]    w_wrow;

    for (genvar g = 0; g < PHYS_COLS; g++) begin : g_col
        fgp_ram #(.WIDTH(EW), .DEPTH(PHYS_ROWS)) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_wrow),
            .i_wdata ({r_vr, r_vc}),
            .i_raddr (r_rd_row),
            .o_rdata (w_rdata[g])
        );
    end

    // Compare of one physical row.
    logic [PHYS_COLS-1:0] w_match, w_hitv;
    logic                 w_any_hit, w_any_m;
    logic [CW-1:0]        w_hit_col, w_hi_col;

    always_comb begin
        w_any_hit = 1'b0;
        w_any_m   = 1'b0;
        w_hit_col = '0;
        w_hi_col  = '0;
        for (int c = 0; c < PHYS_COLS; c++) begin
            w_match[c] = r_valid[r_cmp_row][c] && (w_rdata[c][EW-1:VCOL_WIDTH] == r_vr);
            w_hitv[c]  = w_match[c] && (w_rdata[c][VCOL_WIDTH-1:0] == r_vc);
            if (w_hitv[c] && !w_any_hit) begin
                w_any_hit = 1'b1;
                w_hit_col = CW'(c);
            end
            if (w_match[c]) begin
                w_any_m  = 1'b1;
                w_hi_col = CW'(c);
            end
        end
    end

    // Placement decision.
    logic [RW+3:0] w_vr_wide;
    logic          w_vr_in;
    logic [RW-1:0] w_vr_row, w_cr;
    logic [CW-1:0] w_cc;
    logic [RW:0]   w_dn;
    logic [CW:0]   w_rt;
    logic          w_place;
    logic [RW-1:0] w_pr;
    logic [CW-1:0] w_pc;
    logic          w_over;
    logic          w_fold;

    always_comb begin
        w_vr_wide = (RW+4)'(r_vr);
        w_vr_in   = w_vr_wide < (RW+4)'(PHYS_ROWS);
        w_vr_row  = w_vr_wide[RW-1:0];
        w_over    = r_cnt[r_vr] > {1'b0, i_limit};
        w_place   = 1'b0;
        w_pr      = '0;
        w_pc      = '0;
        w_cr      = r_lfound ? r_lr : w_vr_row;
        w_cc      = r_lfound ? r_lc : '0;
        w_dn      = {1'b0, w_cr} + 1'b1;
        w_rt      = {1'b0, w_cc} + 1'b1;
        if (!r_lfound && !w_vr_in) begin
            w_place = 1'b0;
        end else if (!r_lfound && !r_valid[w_vr_row][0]) begin
            w_place = 1'b1;
            w_pr    = w_vr_row;
            w_pc    = '0;
        end else if (w_rt < (CW+1)'(PHYS_COLS) && !r_valid[w_cr][w_rt[CW-1:0]]) begin
            w_place = 1'b1;
            w_pr    = w_cr;
            w_pc    = w_rt[CW-1:0];
        end else if (i_fold_en && w_cc != '0 && w_dn < (RW+1)'(PHYS_ROWS)
                     && !r_valid[w_dn[RW-1:0]][w_cc]) begin
            w_place = 1'b1;
            w_pr    = w_dn[RW-1:0];
            w_pc    = w_cc;
        end else if (i_fold_en && w_cc > CW'(1) && !r_valid[w_cr][w_cc - 1'b1]) begin
            w_place = 1'b1;
            w_pr    = w_cr;
            w_pc    = w_cc - 1'b1;
        end else if (i_fold_en && w_cc != '0 && w_cr != '0
                     && !r_valid[w_cr - 1'b1][w_cc]) begin
            w_place = 1'b1;
            w_pr    = w_cr - 1'b1;
            w_pc    = w_cc;
        end
        w_fold = (RW+4)'(w_pr) != w_vr_wide;
    end

    logic w_do_place;
    assign w_do_place = i_cmd.exec && r_cmd == fgp_pkg::CMD_MAP && !r_hit && !w_over && w_place;
    assign w_wrow = w_pr;

    always_comb begin
        w_we = '0;
        if (w_do_place) begin
            w_we[w_pc] = 1'b1;
        end
    end

    // Request latch and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_req.cmd;
            r_vr  <= i_req.virt_row;
            r_vc  <= VCOL_WIDTH'(i_req.virt_col);
        end
        r_cmp_row <= r_rd_row;
        if (i_cmd.scan) begin
            r_hit    <= 1'b0;
            r_lfound <= 1'b0;
        end else if (r_cmp_act && r_cmd == fgp_pkg::CMD_MAP) begin
            if (w_any_hit && !r_hit) begin
                r_hit <= 1'b1;
                r_hr  <= r_cmp_row;
                r_hc  <= w_hit_col;
            end
            if (w_any_m && (!r_lfound || w_hi_col > r_lc)) begin
                r_lfound <= 1'b1;
                r_lr     <= r_cmp_row;
                r_lc     <= w_hi_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_act  <= 1'b0;
            r_cmp_act <= 1'b0;
            r_rd_row  <= '0;
        end else begin
            r_cmp_act <= r_rd_act;
            if (i_cmd.scan) begin
                r_rd_act <= 1'b1;
                r_rd_row <= '0;
            end else if (r_rd_act) begin
                if (r_rd_row == RW'(PHYS_ROWS - 1)) begin
                    r_rd_act <= 1'b0;
                end else begin
                    r_rd_row <= r_rd_row + 1'b1;
                end
            end
        end
    end

    // Occupancy, counts, marks and the fold counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < PHYS_ROWS; r++) begin
                r_valid[r] <= '0;
            end
            for (int v = 0; v < 16; v++) begin
                r_cnt[v] <= '0;
            end
            r_mark     <= '0;
            r_fold_cnt <= '0;
        end else begin
            if (r_cmp_act && r_cmd == fgp_pkg::CMD_EVICT) begin
                r_valid[r_cmp_row] <= r_valid[r_cmp_row] & ~w_match;
            end
            if (i_cmd.exec) begin
                case (r_cmd)
                    fgp_pkg::CMD_MAP: begin
                        if (!r_hit && !w_over) begin
                            if (r_cnt[r_vr] != fgp_pkg::CNT_W'(fgp_pkg::CNT_MAX)) begin
                                r_cnt[r_vr] <= r_cnt[r_vr] + 1'b1;
                            end
                            if (w_place) begin
                                r_valid[w_pr][w_pc] <= 1'b1;
                                if (w_fold) begin
                                    r_fold_cnt   <= r_fold_cnt + 1'b1;
                                    r_mark[r_vr] <= 1'b1;
                                end
                            end
                        end
                    end
                    fgp_pkg::CMD_EVICT: begin
                        r_mark[r_vr] <= 1'b0;
                    end
                    fgp_pkg::CMD_CLEAR: begin
                        for (int v = 0; v < 16; v++) begin
                            r_cnt[v] <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Response register.
    fgp_pkg::t_rsp w_rsp;

    always_comb begin
        w_rsp            = '0;
        w_rsp.status     = fgp_pkg::ST_DONE;
        w_rsp.row_folded = r_mark[r_vr];
        w_rsp.fold_total = r_fold_cnt;
        if (r_cmd == fgp_pkg::CMD_MAP) begin
            if (r_hit) begin
                w_rsp.status   = fgp_pkg::ST_PRESENT;
                w_rsp.phys_row = 4'(r_hr);
                w_rsp.phys_col = 4'(r_hc);
            end else if (w_over) begin
                w_rsp.status = fgp_pkg::ST_LIMIT;
            end else if (!w_place) begin
                w_rsp.status = fgp_pkg::ST_NOCELL;
            end else begin
                w_rsp.status   = fgp_pkg::ST_PLACED;
                w_rsp.phys_row = 4'(w_pr);
                w_rsp.phys_col = 4'(w_pc);
                if (w_fold) begin
                    w_rsp.row_folded = 1'b1;
                    w_rsp.fold_total = r_fold_cnt + 1'b1;
                end
            end
        end else if (r_cmd == fgp_pkg::CMD_EVICT) begin
            w_rsp.row_folded = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.exec) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_sts.scan_done = r_cmp_act && (r_cmp_row == RW'(PHYS_ROWS - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_rsp           = r_rsp;

`ifndef NO_ASSERTIONS
    a_exec_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_rd_act && !r_cmp_act))
        else $error("execute step overlaps the row scan");
    a_fold_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fold_cnt == $past(r_fold_cnt)) || (r_fold_cnt == $past(r_fold_cnt) + 32'd1))
        else $error("fold counter moved by more than one");
    a_place_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_place |-> !r_valid[w_pr][w_pc])
        else $error("placement into an occupied cell");
`endif

endmodule

FILE: rtl/folding_grid_placement.sv
// Folding grid placement.
// Requests enter on the input channel (i_in_valid, o_in_stall, i_in_req) and
// each produces exactly one response on the output channel (o_out_valid,
// i_out_stall, o_out_rsp). A map request looks up an element, then places it
// next to its row's rightmost cell; evict frees a virtual row; clear resets
// the per-row request counts.
// Map and evict walk the cell grid one physical row per cycle through the
// column memories, reading each row and then comparing it, before the final
// step loads the response register; clear and unknown commands go straight
// to the final step. One request is in work at a time, so the next request
// is taken only after the final step of the last one. A finished response
// waits in the output register; the block then takes the next request while
// it is held, and only its final step waits for the register to free up.
// Synchronous reset frees every cell, clears counts, folded marks and the
// fold counter, and sets folding off with a request limit of four. The
// element memories need no clearing pass. The user must write configuration
// over the APB port only while the block is idle; the block itself does not
// enforce this.
module folding_grid_placement #(
    parameter int PHYS_ROWS  = 16,
    parameter int PHYS_COLS  = 16,
    parameter int VCOL_WIDTH = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fgp_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output fgp_pkg::t_rsp o_out_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    // Configuration registers; the register index is the word address.
    logic       r_fold_en;
    logic [3:0] r_limit;
    logic       w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_en <= 1'b0;
            r_limit   <= 4'd4;
        end else if (w_wr) begin
            if (paddr[2] == fgp_pkg::REG_FOLD_EN) begin
                r_fold_en <= pwdata[0];
            end else begin
                r_limit <= pwdata[3:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == fgp_pkg::REG_LIMIT) begin
            prdata[3:0] = r_limit;
        end else begin
            prdata[0] = r_fold_en;
        end
    end

    // The controller sequences the scan and final step; the datapath holds
    // the grid state and the response register.
    fgp_pkg::t_cmd w_cmd;
    fgp_pkg::t_sts w_sts;
    logic          w_idle;

    fgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cmd   (i_in_req.cmd),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    fgp_datapath #(
        .PHYS_ROWS  (PHYS_ROWS),
        .PHYS_COLS  (PHYS_COLS),
        .VCOL_WIDTH (VCOL_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req       (i_in_req),
        .i_fold_en   (r_fold_en),
        .i_limit     (r_limit),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_out_rsp)
    );

    // A request is only taken while no other request is in work.
    assign o_in_stall = !w_idle;

endmodule
